/* hw/rtl/kmd_pkg.sv */
package kmd_pkg;

  // fixed field widths of the channels
  localparam int COL_W      = 3;
  localparam int ROWIN_W    = 16;
  localparam int QROW_W     = 4;
  localparam int DBS_W      = 8;
  localparam int ROWSTATE_W = 8;
  localparam int KCNT_W     = 8;

  // debounce value after reset, also the countdown reset value
  localparam logic [DBS_W-1:0] DEBOUNCE_RESET = 8'd10;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_UPD  = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_CPY  = 7'b0001000,
    S_QRY  = 7'b0010000,
    S_SCAN = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // controls from the sequencer to the row statistics unit
  typedef struct packed {
    logic clr;
    logic q_cap;
    logic row_vld;
  } scan_ctl_t;

endpackage

/* hw/rtl/kmd_if.sv */
// input word channel: one sampled column
interface kmd_in_if;
  logic                         valid;
  logic                         ready;
  logic [kmd_pkg::COL_W-1:0]    column;
  logic [kmd_pkg::ROWIN_W-1:0]  row_bits;
  logic                         last_col;
  logic [kmd_pkg::QROW_W-1:0]   query_row;

  modport source (output valid, column, row_bits, last_col, query_row, input ready);
  modport sink   (input valid, column, row_bits, last_col, query_row, output ready);
endinterface

// result word channel
interface kmd_out_if;
  logic                           valid;
  logic                           ready;
  logic                           settled;
  logic                           bounce;
  logic                           committed_now;
  logic [kmd_pkg::ROWSTATE_W-1:0] row_state;
  logic                           row_ghost;
  logic [kmd_pkg::KCNT_W-1:0]     key_count;

  modport source (output valid, settled, bounce, committed_now, row_state, row_ghost,
                  key_count, input ready);
  modport sink   (input valid, settled, bounce, committed_now, row_state, row_ghost,
                  key_count, output ready);
endinterface

// configuration write channel
interface kmd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [kmd_pkg::DBS_W-1:0]   debounce_scans;

  modport source (output valid, debounce_scans, input ready);
  modport sink   (input valid, debounce_scans, output ready);
endinterface

/* hw/rtl/key_matrix_debounce.sv */
// Debounced keyboard matrix scanner. Each input word is one sampled column; each
// accepted word gives exactly one result word. The raw and the settled matrix live
// in two single-port-read memories of ROWS rows by COLS bits, and every item walks
// them one row per cycle through the single read port: an update sweep of the raw
// matrix, a countdown step, a copy sweep into the settled matrix only when the
// countdown expires, a fetch of the queried row and a statistics sweep of the
// settled matrix. The next word is taken once the result is handed to the output
// register. No clearing pass is needed after reset: per-row valid bits make both
// matrices read as zero until written. The debounce value may be written at any
// idle time; zero acts as one.
module key_matrix_debounce #(
  parameter int ROWS = 16,
  parameter int COLS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  kmd_in_if.sink    in_ch,
  kmd_out_if.source out_ch,
  kmd_cfg_if.sink   cfg_ch
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(ROWS + 1);
  localparam int KW = $clog2(ROWS * COLS + 1);

  kmd_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          rvld_r;
  logic [AW-1:0] ridx_r;

  logic [kmd_pkg::COL_W-1:0]   column_r;
  logic [kmd_pkg::ROWIN_W-1:0] row_bits_r;
  logic                        last_r;
  logic [kmd_pkg::QROW_W-1:0]  query_r;

  logic [kmd_pkg::DBS_W-1:0] dbs_r;
  logic [kmd_pkg::DBS_W-1:0] cd_r, cd_nxt;
  logic                      bounce_r, bounce_nxt;
  logic                      commit_r, commit_nxt;

  logic [ROWS-1:0] raw_vld_r;
  logic [ROWS-1:0] set_vld_r;
  logic            raw_rv_r;
  logic            set_rv_r;

  logic                           out_valid_r;
  logic                           out_settled_r;
  logic                           out_bounce_r;
  logic                           out_commit_r;
  logic [kmd_pkg::ROWSTATE_W-1:0] out_row_r;
  logic                           out_ghost_r;
  logic [kmd_pkg::KCNT_W-1:0]     out_count_r;

  logic                      accept;
  logic                      sweep;
  logic                      issue;
  logic                      cnt_last;
  logic [AW-1:0]             qa;
  logic [AW-1:0]             raw_raddr;
  logic [AW-1:0]             set_raddr;
  logic [COLS-1:0]           raw_rdata;
  logic [COLS-1:0]           set_rdata;
  logic [COLS-1:0]           raw_row;
  logic [COLS-1:0]           set_row;
  logic                      raw_we;
  logic                      set_we;
  logic                      col_ok;
  logic [COLS-1:0]           cmask;
  logic [kmd_pkg::ROWIN_W-1:0] row_shift;
  logic                      raw_bit;
  logic                      flip;
  logic [COLS-1:0]           raw_new;
  logic [kmd_pkg::DBS_W-1:0] reload;
  logic                      out_free;
  logic                      q_ok;
  kmd_pkg::scan_ctl_t        scan_ctl;
  logic [COLS-1:0]           qbits;
  logic                      ghost;
  logic [KW-1:0]             count;

  // handshakes
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == kmd_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // row sweep counter shared by the three passes
  assign sweep    = (state_r == kmd_pkg::S_UPD) || (state_r == kmd_pkg::S_CPY) ||
                    (state_r == kmd_pkg::S_SCAN);
  assign issue    = sweep && (cnt_r < CW'(ROWS));
  assign cnt_last = sweep && (cnt_r == CW'(ROWS));
  assign qa       = AW'(query_r);

  // memory addressing
  assign raw_raddr = cnt_r[AW-1:0];
  assign set_raddr = (state_r == kmd_pkg::S_QRY) ? qa : cnt_r[AW-1:0];
  assign raw_row   = raw_rv_r ? raw_rdata : '0;
  assign set_row   = set_rv_r ? set_rdata : '0;
  assign raw_we    = (state_r == kmd_pkg::S_UPD) && rvld_r;
  assign set_we    = (state_r == kmd_pkg::S_CPY) && rvld_r;

  kmd_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (ridx_r),
    .wdata (raw_new),
    .raddr (raw_raddr),
    .rdata (raw_rdata)
  );

  kmd_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_set_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (ridx_r),
    .wdata (raw_row),
    .raddr (set_raddr),
    .rdata (set_rdata)
  );

  // compare sampled bit against the raw bit of the driven column
  assign col_ok    = (32'(column_r) < COLS);
  assign cmask     = col_ok ? (COLS'(1) << column_r) : '0;
  assign row_shift = row_bits_r >> ridx_r;
  assign raw_bit   = |(raw_row & cmask);
  assign flip      = raw_we && col_ok && (raw_bit != row_shift[0]);
  assign raw_new   = raw_row ^ (flip ? cmask : '0);
  assign reload    = (dbs_r == '0) ? kmd_pkg::DBS_W'(1) : dbs_r;

  // settled matrix statistics
  assign scan_ctl.clr     = (state_r == kmd_pkg::S_QRY);
  assign scan_ctl.q_cap   = (state_r == kmd_pkg::S_SCAN) && (cnt_r == '0);
  assign scan_ctl.row_vld = (state_r == kmd_pkg::S_SCAN) && rvld_r;

  kmd_scan #(.ROWS(ROWS), .COLS(COLS)) u_scan (
    .clk   (clk),
    .ctl   (scan_ctl),
    .ridx  (ridx_r),
    .qa    (qa),
    .row   (set_row),
    .qbits (qbits),
    .ghost (ghost),
    .count (count)
  );

  assign q_ok = (32'(query_r) < ROWS);

  // sequencer and countdown
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cd_nxt     = cd_r;
    bounce_nxt = bounce_r;
    commit_nxt = commit_r;
    if (cnt_last) begin
      cnt_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    case (state_r)
      kmd_pkg::S_IDLE: begin
        if (accept) begin
          bounce_nxt = 1'b0;
          commit_nxt = 1'b0;
          state_nxt  = kmd_pkg::S_UPD;
        end
      end
      kmd_pkg::S_UPD: begin
        if (flip) begin
          if (cd_r != '0) begin
            bounce_nxt = 1'b1;
          end
          cd_nxt = reload;
        end
        if (cnt_last) begin
          state_nxt = kmd_pkg::S_DEC;
        end
      end
      kmd_pkg::S_DEC: begin
        state_nxt = kmd_pkg::S_QRY;
        if (last_r && (cd_r != '0)) begin
          cd_nxt = cd_r - kmd_pkg::DBS_W'(1);
          if (cd_r == kmd_pkg::DBS_W'(1)) begin
            commit_nxt = 1'b1;
            state_nxt  = kmd_pkg::S_CPY;
          end
        end
      end
      kmd_pkg::S_CPY: begin
        if (cnt_last) begin
          state_nxt = kmd_pkg::S_QRY;
        end
      end
      kmd_pkg::S_QRY: begin
        state_nxt = kmd_pkg::S_SCAN;
      end
      kmd_pkg::S_SCAN: begin
        if (cnt_last) begin
          state_nxt = kmd_pkg::S_DONE;
        end
      end
      kmd_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = kmd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kmd_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kmd_pkg::S_IDLE;
      cnt_r     <= '0;
      rvld_r    <= 1'b0;
      dbs_r     <= kmd_pkg::DEBOUNCE_RESET;
      cd_r      <= kmd_pkg::DEBOUNCE_RESET;
      bounce_r  <= 1'b0;
      commit_r  <= 1'b0;
      raw_vld_r <= '0;
      set_vld_r <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rvld_r   <= issue;
      cd_r     <= cd_nxt;
      bounce_r <= bounce_nxt;
      commit_r <= commit_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        dbs_r <= cfg_ch.debounce_scans;
      end
      if (raw_we) begin
        raw_vld_r[ridx_r] <= 1'b1;
      end
      if (set_we) begin
        set_vld_r[ridx_r] <= 1'b1;
      end
    end
  end

  // input word capture and read-side bookkeeping
  always_ff @(posedge clk) begin
    ridx_r   <= cnt_r[AW-1:0];
    raw_rv_r <= raw_vld_r[raw_raddr];
    set_rv_r <= set_vld_r[set_raddr];
    if (accept) begin
      column_r   <= in_ch.column;
      row_bits_r <= in_ch.row_bits;
      last_r     <= in_ch.last_col;
      query_r    <= in_ch.query_row;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == kmd_pkg::S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == kmd_pkg::S_DONE) && out_free) begin
      out_settled_r <= (cd_r == '0);
      out_bounce_r  <= bounce_r;
      out_commit_r  <= commit_r;
      out_row_r     <= q_ok ? kmd_pkg::ROWSTATE_W'(qbits) : '0;
      out_ghost_r   <= q_ok && ghost;
      out_count_r   <= (32'(count) > 255) ? {kmd_pkg::KCNT_W{1'b1}}
                                          : kmd_pkg::KCNT_W'(count);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.settled       = out_settled_r;
  assign out_ch.bounce        = out_bounce_r;
  assign out_ch.committed_now = out_commit_r;
  assign out_ch.row_state     = out_row_r;
  assign out_ch.row_ghost     = out_ghost_r;
  assign out_ch.key_count     = out_count_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(ROWS))
    else $error("row sweep counter past the last row");

  a_copy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kmd_pkg::S_CPY) |-> (last_r && (cd_r == '0) && commit_r))
    else $error("matrix copy without an expired countdown at end of scan");

  a_commit_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_commit_r) |-> out_settled_r)
    else $error("commit reported while countdown still pending");

  a_load_settled: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == kmd_pkg::S_DONE) && out_free) |=>
      (out_valid_r && (out_settled_r == (cd_r == '0))))
    else $error("settled flag does not match countdown");

endmodule

/* hw/rtl/kmd_ram.sv */
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/kmd_scan.sv */
module kmd_scan #(
  parameter int ROWS  = 16,
  parameter int COLS  = 8,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int KW   = $clog2(ROWS * COLS + 1),
  localparam int PW   = $clog2(COLS + 1)
) (
  input  logic               clk,
  input  kmd_pkg::scan_ctl_t ctl,
  input  logic [AW-1:0]      ridx,
  input  logic [AW-1:0]      qa,
  input  logic [COLS-1:0]    row,
  output logic [COLS-1:0]    qbits,
  output logic               ghost,
  output logic [KW-1:0]      count
);

  logic [COLS-1:0] qbits_r;
  logic [KW-1:0]   acc_r;
  logic [KW-1:0]   acc_nxt;
  logic            ovl_r;
  logic            ovl_nxt;
  logic [PW-1:0]   row_ones;

  // ones in the settled row now on the read port
  always_comb begin
    row_ones = '0;
    for (int c = 0; c < COLS; c++) begin
      row_ones = row_ones + PW'(row[c]);
    end
  end

  // key count and overlap with the queried row, one row a cycle
  always_comb begin
    acc_nxt = acc_r;
    ovl_nxt = ovl_r;
    if (ctl.clr) begin
      acc_nxt = '0;
      ovl_nxt = 1'b0;
    end else if (ctl.row_vld) begin
      acc_nxt = acc_r + KW'(row_ones);
      if ((ridx != qa) && ((row & qbits_r) != '0)) begin
        ovl_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ovl_r <= ovl_nxt;
    if (ctl.q_cap) begin
      qbits_r <= row;
    end
  end

  // ghost needs at least two keys in the queried row
  assign qbits = qbits_r;
  assign ghost = ovl_r && (((qbits_r - COLS'(1)) & qbits_r) != '0);
  assign count = acc_r;

endmodule
